// ===== hw/rtl/cht_pkg.sv =====
// Shared types and constants for the cuckoo hash table unit.
package cht_pkg;

    localparam int unsigned LogSizeDefault = 10;
    localparam int unsigned CountWidth     = 12;
    localparam int unsigned WordWidth      = 32;

    localparam logic [WordWidth-1:0]  MultOneReset   = 32'd2654435769;
    localparam logic [WordWidth-1:0]  MultTwoReset   = 32'd2246822519;
    localparam logic [CountWidth-1:0] LoadLimitReset = 12'd1023;
    localparam logic [CountWidth-1:0] CountMax       = 12'hFFF;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] REG_MULT_ONE   = 2'd0;
    localparam logic [1:0] REG_MULT_TWO   = 2'd1;
    localparam logic [1:0] REG_LOAD_LIMIT = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_LOAD    = 3'd4;
    localparam logic [2:0] ST_KICK    = 3'd5;

    typedef struct packed {
        logic [1:0]           mode;
        logic [WordWidth-1:0] key;
        logic [WordWidth-1:0] value;
    } t_cht_in;

    typedef struct packed {
        logic [2:0]            status;
        logic [WordWidth-1:0]  found_value;
        logic [WordWidth-1:0]  homeless_key;
        logic [CountWidth-1:0] count_now;
    } t_cht_out;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_HASH,
        OP_READ,
        OP_EVAL,
        OP_WR1,
        OP_WR2
    } t_cht_op;

    typedef struct packed {
        t_cht_op op;
        logic    emit;
    } t_cht_cmd;

    typedef struct packed {
        logic clr_done;
        logic start_insert;
        logic free1;
        logic free2;
        logic last_round;
    } t_cht_stat;

endpackage

// ===== hw/rtl/cht_ctrl.sv =====
// Sequencer for clearing, probing and the displacement loop.
module cht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  cht_pkg::t_cht_stat i_stat,
    output cht_pkg::t_cht_cmd  o_cmd
);
    import cht_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_EVAL, S_WR1,
        S_KHASH2, S_KREAD2, S_WR2, S_KHASH1, S_KREAD1, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd.op    = OP_NONE;
        o_cmd.emit  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.op = OP_HASH;
                n_state  = S_READ;
            end
            S_READ: begin
                o_cmd.op = OP_READ;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.op = OP_EVAL;
                n_state  = i_stat.start_insert ? S_WR1 : S_DONE;
            end
            S_WR1: begin
                o_cmd.op = OP_WR1;
                n_state  = i_stat.free1 ? S_DONE : S_KHASH2;
            end
            S_KHASH2: begin
                o_cmd.op = OP_HASH;
                n_state  = S_KREAD2;
            end
            S_KREAD2: begin
                o_cmd.op = OP_READ;
                n_state  = S_WR2;
            end
            S_WR2: begin
                o_cmd.op = OP_WR2;
                n_state  = (i_stat.free2 || i_stat.last_round) ? S_DONE : S_KHASH1;
            end
            S_KHASH1: begin
                o_cmd.op = OP_HASH;
                n_state  = S_KREAD1;
            end
            S_KREAD1: begin
                o_cmd.op = OP_READ;
                n_state  = S_WR1;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/cht_dp.sv =====
// Hash units, key/value stores, item count and result registers.
module cht_dp #(
    parameter int unsigned LOG_SIZE = cht_pkg::LogSizeDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cht_pkg::t_cht_in                  i_in,
    input  logic [cht_pkg::WordWidth-1:0]     i_mult_one,
    input  logic [cht_pkg::WordWidth-1:0]     i_mult_two,
    input  logic [cht_pkg::CountWidth-1:0]    i_load_limit,
    input  cht_pkg::t_cht_cmd                 i_cmd,
    output cht_pkg::t_cht_stat                o_stat,
    output cht_pkg::t_cht_out                 o_out
);
    import cht_pkg::*;

    localparam int unsigned Slots      = 1 << LOG_SIZE;
    localparam int unsigned KickRounds = 3 * LOG_SIZE;
    localparam int unsigned RoundWidth = $clog2(KickRounds + 1);
    localparam logic [RoundWidth-1:0] LastRound = RoundWidth'(KickRounds - 1);

    logic [WordWidth-1:0] r_fkeys [Slots];
    logic [WordWidth-1:0] r_fvals [Slots];
    logic [WordWidth-1:0] r_skeys [Slots];
    logic [WordWidth-1:0] r_svals [Slots];

    logic [1:0]            r_mode;
    logic [WordWidth-1:0]  r_ck, r_cv;
    logic [LOG_SIZE-1:0]   r_slot1, r_slot2, r_clr_idx;
    logic [WordWidth-1:0]  r_rk1, r_rv1, r_rk2, r_rv2;
    logic [CountWidth-1:0] r_count;
    logic [RoundWidth-1:0] r_round;
    logic [2:0]            r_status;
    logic [WordWidth-1:0]  r_data, r_lost;
    t_cht_out              r_out;

    logic [WordWidth-1:0]  w_prod1, w_prod2;
    logic                  w_hit1, w_hit2;
    logic [CountWidth-1:0] w_cnt_a, w_cnt_b;
    logic                  w_we1, w_we2;
    logic [LOG_SIZE-1:0]   w_wa1, w_wa2;
    logic [WordWidth-1:0]  w_wk1, w_wk2;

    assign w_prod1 = r_ck * i_mult_one;
    assign w_prod2 = r_ck * i_mult_two;

    assign w_hit1 = (r_ck != '0) && (r_rk1 == r_ck);
    assign w_hit2 = (r_ck != '0) && (r_rk2 == r_ck);

    // saturating decrement for each hit of a delete
    assign w_cnt_a = (w_hit1 && r_count != '0) ? r_count - 1'b1 : r_count;
    assign w_cnt_b = (w_hit2 && w_cnt_a != '0) ? w_cnt_a - 1'b1 : w_cnt_a;

    assign o_stat.clr_done     = &r_clr_idx;
    assign o_stat.start_insert = (r_mode == MODE_INSERT) && (r_ck != '0) && !w_hit1
                                 && !w_hit2 && (r_count < i_load_limit);
    assign o_stat.free1        = (r_rk1 == '0);
    assign o_stat.free2        = (r_rk2 == '0);
    assign o_stat.last_round   = (r_round == LastRound);
    assign o_out               = r_out;

    always_comb begin
        w_we1 = 1'b0;
        w_we2 = 1'b0;
        w_wa1 = r_slot1;
        w_wa2 = r_slot2;
        w_wk1 = '0;
        w_wk2 = '0;
        case (i_cmd.op)
            OP_CLEAR: begin
                w_we1 = 1'b1;
                w_we2 = 1'b1;
                w_wa1 = r_clr_idx;
                w_wa2 = r_clr_idx;
            end
            OP_EVAL: begin
                w_we1 = (r_mode == MODE_DELETE) && w_hit1;
                w_we2 = (r_mode == MODE_DELETE) && w_hit2;
            end
            OP_WR1: begin
                w_we1 = 1'b1;
                w_wk1 = r_ck;
            end
            OP_WR2: begin
                w_we2 = 1'b1;
                w_wk2 = r_ck;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we1) r_fkeys[w_wa1] <= w_wk1;
        if (i_cmd.op == OP_WR1) r_fvals[r_slot1] <= r_cv;
        if (i_cmd.op == OP_READ) begin
            r_rk1 <= r_fkeys[r_slot1];
            r_rv1 <= r_fvals[r_slot1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we2) r_skeys[w_wa2] <= w_wk2;
        if (i_cmd.op == OP_WR2) r_svals[r_slot2] <= r_cv;
        if (i_cmd.op == OP_READ) begin
            r_rk2 <= r_skeys[r_slot2];
            r_rv2 <= r_svals[r_slot2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_clr_idx <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR: r_clr_idx <= r_clr_idx + 1'b1;
                OP_EVAL:  if (r_mode == MODE_DELETE) r_count <= w_cnt_b;
                OP_WR1:   if (r_rk1 == '0 && r_count != CountMax) r_count <= r_count + 1'b1;
                OP_WR2:   if (r_rk2 == '0 && r_count != CountMax) r_count <= r_count + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode  <= i_in.mode;
                r_ck    <= i_in.key;
                r_cv    <= i_in.value;
                r_round <= '0;
            end
            OP_HASH: begin
                r_slot1 <= w_prod1[WordWidth-1 -: LOG_SIZE];
                r_slot2 <= w_prod2[WordWidth-1 -: LOG_SIZE];
            end
            OP_EVAL: begin
                r_status <= ST_MISS;
                r_data   <= '0;
                r_lost   <= '0;
                case (r_mode)
                    MODE_LOOKUP: begin
                        if (w_hit1) begin
                            r_status <= ST_OK;
                            r_data   <= r_rv1;
                        end else if (w_hit2) begin
                            r_status <= ST_OK;
                            r_data   <= r_rv2;
                        end
                    end
                    MODE_DELETE: if (w_hit1 || w_hit2) r_status <= ST_OK;
                    MODE_INSERT: begin
                        if (r_ck == '0)                  r_status <= ST_INVALID;
                        else if (w_hit1 || w_hit2)       r_status <= ST_DUP;
                        else if (r_count >= i_load_limit) r_status <= ST_LOAD;
                    end
                    default: ;
                endcase
            end
            OP_WR1: begin
                if (r_rk1 == '0) begin
                    r_status <= ST_OK;
                    r_data   <= '0;
                    r_lost   <= '0;
                end else begin
                    r_ck <= r_rk1;
                    r_cv <= r_rv1;
                end
            end
            OP_WR2: begin
                r_round <= r_round + 1'b1;
                if (r_rk2 == '0) begin
                    r_status <= ST_OK;
                    r_data   <= '0;
                    r_lost   <= '0;
                end else begin
                    r_ck     <= r_rk2;
                    r_cv     <= r_rv2;
                    r_status <= ST_KICK;
                    r_data   <= r_rv2;
                    r_lost   <= r_rk2;
                end
            end
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_out.status       <= r_status;
            r_out.found_value  <= r_data;
            r_out.homeless_key <= r_lost;
            r_out.count_now    <= r_count;
        end
    end

endmodule

// ===== hw/rtl/cuckoo_hash_table_unit.sv =====
// Top level of the two-table cuckoo hash unit with its register port.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in  (mode, key, value)
//   out      output     o_out_valid / i_out_stall o_out (status, found_value,
//                                                        homeless_key, count_now)
//   cfg      input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Lookup, delete and refused inserts pass the hash, read and evaluate states
// before the result is emitted. Inserts add the first-table write and a hash,
// read and write per further displacement; each step is bound by the single
// read port of each store. After reset every slot of both key stores is cleared,
// during which o_in_stall is high. A new transaction is taken while a finished
// result waits in the output register.
module cuckoo_hash_table_unit #(
    parameter int unsigned LOG_SIZE = cht_pkg::LogSizeDefault
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cht_pkg::t_cht_in                 i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output cht_pkg::t_cht_out                o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [cht_pkg::WordWidth-1:0]    pwdata,
    output logic [cht_pkg::WordWidth-1:0]    prdata,
    output logic                             pready
);
    import cht_pkg::*;

    logic [WordWidth-1:0]  r_mult_one, r_mult_two;
    logic [CountWidth-1:0] r_load_limit;
    logic                  w_wr;
    t_cht_cmd              w_cmd;
    t_cht_stat             w_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult_one   <= MultOneReset;
            r_mult_two   <= MultTwoReset;
            r_load_limit <= LoadLimitReset;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MULT_ONE:   r_mult_one   <= pwdata;
                REG_MULT_TWO:   r_mult_two   <= pwdata;
                REG_LOAD_LIMIT: r_load_limit <= pwdata[CountWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MULT_ONE:   prdata = r_mult_one;
            REG_MULT_TWO:   prdata = r_mult_two;
            REG_LOAD_LIMIT: prdata = {{(WordWidth-CountWidth){1'b0}}, r_load_limit};
            default:        prdata = '0;
        endcase
    end

    cht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cht_dp #(
        .LOG_SIZE (LOG_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_mult_one   (r_mult_one),
        .i_mult_two   (r_mult_two),
        .i_load_limit (r_load_limit),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out        (o_out)
    );

endmodule

// ===== sim/cuckoo_hash_table_unit_checker.sv =====
// Transaction monitor and cuckoo table predictor for the hash table unit.
module cuckoo_hash_table_unit_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  cht_pkg::t_cht_in  i_in,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  cht_pkg::t_cht_out i_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [3:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);
    import cht_pkg::*;

    localparam int Log = LogSizeDefault;
    localparam int Slots = 1 << Log;

    logic [31:0] mult_one, mult_two;
    logic [11:0] limit, stored_count;
    logic [31:0] t1_key [Slots];
    logic [31:0] t1_val [Slots];
    logic [31:0] t2_key [Slots];
    logic [31:0] t2_val [Slots];
    t_cht_out    answers_due [$];

    function automatic int slot_of(logic [31:0] k, logic [31:0] m);
        logic [31:0] prod;
        prod = k * m;
        return int'(prod >> (32 - Log));
    endfunction

    function automatic t_cht_out run_op(t_cht_in req);
        t_cht_out    ans;
        int          s1, s2, pos;
        logic        hit1, hit2, placed;
        logic [31:0] ck, cv, ok_k, ok_v;
        ans = '0;
        ans.status = ST_MISS;
        s1 = slot_of(req.key, mult_one);
        s2 = slot_of(req.key, mult_two);
        hit1 = req.key != 0 && t1_key[s1] == req.key;
        hit2 = req.key != 0 && t2_key[s2] == req.key;
        if (req.mode == MODE_LOOKUP) begin
            if (hit1) begin
                ans.status = ST_OK;
                ans.found_value = t1_val[s1];
            end else if (hit2) begin
                ans.status = ST_OK;
                ans.found_value = t2_val[s2];
            end
        end else if (req.mode == MODE_DELETE) begin
            if (hit1) begin
                t1_key[s1] = '0;
                if (stored_count > 0) stored_count--;
            end
            if (hit2) begin
                t2_key[s2] = '0;
                if (stored_count > 0) stored_count--;
            end
            if (hit1 || hit2) ans.status = ST_OK;
        end else if (req.mode == MODE_INSERT) begin
            if (req.key == 0) begin
                ans.status = ST_INVALID;
            end else if (hit1 || hit2) begin
                ans.status = ST_DUP;
            end else if (stored_count >= limit) begin
                ans.status = ST_LOAD;
            end else begin
                ck = req.key;
                cv = req.value;
                placed = 1'b0;
                for (int r = 0; r < 3 * Log && !placed; r++) begin
                    pos = slot_of(ck, mult_one);
                    ok_k = t1_key[pos];
                    ok_v = t1_val[pos];
                    t1_key[pos] = ck;
                    t1_val[pos] = cv;
                    ck = ok_k;
                    cv = ok_v;
                    if (ok_k == 0) begin
                        placed = 1'b1;
                    end else begin
                        pos = slot_of(ck, mult_two);
                        ok_k = t2_key[pos];
                        ok_v = t2_val[pos];
                        t2_key[pos] = ck;
                        t2_val[pos] = cv;
                        ck = ok_k;
                        cv = ok_v;
                        if (ok_k == 0) placed = 1'b1;
                    end
                end
                if (placed) begin
                    ans.status = ST_OK;
                    if (stored_count < CountMax) stored_count++;
                end else begin
                    ans.status = ST_KICK;
                    ans.found_value = cv;
                    ans.homeless_key = ck;
                end
            end
        end
        ans.count_now = stored_count;
        return ans;
    endfunction

    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        t_cht_out want;
        if (!i_rst_n) begin
            mult_one <= MultOneReset;
            mult_two <= MultTwoReset;
            limit <= LoadLimitReset;
            stored_count = '0;
            for (int i = 0; i < Slots; i++) begin
                t1_key[i] = '0;
                t2_key[i] = '0;
                t1_val[i] = '0;
                t2_val[i] = '0;
            end
            answers_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_MULT_ONE: mult_one <= i_pwdata;
                    REG_MULT_TWO: mult_two <= i_pwdata;
                    REG_LOAD_LIMIT: limit <= i_pwdata[11:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %p", i_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (want.status !== i_out.status
                            || want.found_value !== i_out.found_value
                            || want.homeless_key !== i_out.homeless_key
                            || want.count_now !== i_out.count_now) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", want, i_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) answers_due.push_back(run_op(i_in));
        end
    end

endmodule

// ===== sim/cuckoo_hash_table_unit_test.sv =====
// Stimulus and verdict for the cuckoo hash table unit.
module cuckoo_hash_table_unit_test;
    import cht_pkg::*;

    logic        i_clk, i_rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    t_cht_in     in_item;
    t_cht_out    out_item;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending, idle_cycles;
    logic        hold_off;
    logic [31:0] live_keys [$];

    cuckoo_hash_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cuckoo_hash_table_unit_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_item),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall pattern, plus long hold-offs on request.
    initial begin
        int phase;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_off) out_stall <= 1'b1;
            else if (phase % 200 < 60) out_stall <= 1'b0;
            else out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || !i_rst_n || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {index, 2'b00};
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_op(logic [1:0] mode, logic [31:0] key, logic [31:0] value);
        in_item = '{mode: mode, key: key, value: value};
        in_valid = 1'b1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        if (mode == MODE_INSERT && key != 0) live_keys.push_back(key);
    endtask

    task automatic pause();
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic random_ops(int n, int key_span);
        logic [1:0]  mode;
        logic [31:0] key;
        int          pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) mode = MODE_INSERT;
            else if (pick < 75) mode = MODE_LOOKUP;
            else if (pick < 97) mode = MODE_DELETE;
            else mode = 2'd3;
            if (live_keys.size() > 0 && $urandom_range(0, 1) == 1)
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else if ($urandom_range(0, 30) == 0)
                key = '0;
            else if (key_span == 0)
                key = $urandom;
            else
                key = $urandom_range(1, key_span);
            send_op(mode, key, $urandom);
            if ($urandom_range(0, 9) == 0) pause();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: invalid key, extremes, duplicate, delete, unused mode.
        send_op(MODE_LOOKUP, 32'd0, 32'd0);
        send_op(MODE_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_op(MODE_DELETE, 32'd0, 32'd0);
        send_op(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(MODE_INSERT, 32'd1, 32'd0);
        send_op(MODE_INSERT, 32'd1, 32'd5);
        send_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'd0);
        send_op(MODE_LOOKUP, 32'd1, 32'hFFFF_FFFF);
        send_op(2'd3, 32'd1, 32'hFFFF_FFFF);
        send_op(MODE_DELETE, 32'd1, 32'd0);
        send_op(MODE_DELETE, 32'd1, 32'd0);
        send_op(MODE_LOOKUP, 32'd1, 32'd0);
        send_op(MODE_LOOKUP, 32'h8000_0000, 32'd0);
        drain();

        // Tiny load limit exercises the load refusal.
        write_reg(REG_LOAD_LIMIT, 32'd2);
        for (int i = 0; i < 6; i++) send_op(MODE_INSERT, 32'h100 + i, $urandom);
        drain();

        // Degenerate multipliers force long displacement chains and kick failure.
        write_reg(REG_MULT_ONE, 32'd0);
        write_reg(REG_MULT_TWO, 32'hFFFF_FFFF);
        write_reg(REG_LOAD_LIMIT, 32'd2048);
        live_keys.delete();
        random_ops(150, 0);
        drain();

        write_reg(REG_MULT_ONE, 32'd1);
        write_reg(REG_MULT_TWO, 32'd0);
        random_ops(150, 0);
        drain();

        // Default-like hashing, small key space for many hits.
        write_reg(REG_MULT_ONE, MultOneReset);
        write_reg(REG_MULT_TWO, MultTwoReset);
        write_reg(REG_LOAD_LIMIT, 32'hFFF);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_ops(500, 2000);
        join
        drain();

        write_reg(REG_LOAD_LIMIT, 32'd0);
        random_ops(60, 500);
        drain();

        write_reg(REG_LOAD_LIMIT, 32'd200);
        random_ops(580, 0);
        drain();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cht_pkg.sv
hw/rtl/cht_ctrl.sv
hw/rtl/cht_dp.sv
hw/rtl/cuckoo_hash_table_unit.sv
sim/cuckoo_hash_table_unit_checker.sv
sim/cuckoo_hash_table_unit_test.sv
